### hw/rtl/adir_pkg.sv
// ----------------------------------------------------------------------------
// adir_pkg - shared types and constants of the audio DMA register block
// Bus codes, register map, rate constants and the divider handshake types.
// ----------------------------------------------------------------------------
package adir_pkg;

   // rate generation constants
   localparam logic [31:0] CLOCK_RATE   = 32'd48681812;
   localparam logic [31:0] PERIOD_CLOCK = 32'd93750000;
   localparam logic [31:0] PERIOD_RESET = PERIOD_CLOCK / CLOCK_RATE;

   // shared divider
   localparam int DIV_WIDTH = 32;
   localparam int DIV_CNT_W = $clog2(DIV_WIDTH);

   // request kinds
   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_PLAYED = 2'd2;

   // register map, index = offset[19:2]
   localparam int IDX_W = 18;
   localparam logic [IDX_W-1:0] REG_ADDRESS  = 18'd0;
   localparam logic [IDX_W-1:0] REG_LENGTH   = 18'd1;
   localparam logic [IDX_W-1:0] REG_CONTROL  = 18'd2;
   localparam logic [IDX_W-1:0] REG_STATUS   = 18'd3;
   localparam logic [IDX_W-1:0] REG_DAC_RATE = 18'd4;
   localparam logic [IDX_W-1:0] REG_BIT_RATE = 18'd5;

   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [DIV_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### hw/rtl/adir_div.sv
// ----------------------------------------------------------------------------
// adir_div - shared iterative unsigned divider
// Restoring divider, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module adir_div (
   input  logic                              clock,
   input  logic                              reset,
   input  adir_pkg::div_req_type             div_req,
   output adir_pkg::div_stat_type            div_stat,
   output logic [adir_pkg::DIV_WIDTH-1:0]    quotient
);

   localparam int W  = adir_pkg::DIV_WIDTH;
   localparam int CW = adir_pkg::DIV_CNT_W;

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W:0]    shifted;
   logic [W:0]    diff;
   logic          fits;

   // trial subtract of the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = ~diff[W];
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient      = quo_ff;

endmodule

### hw/rtl/audio_dma_interface_registers_top.sv
// ----------------------------------------------------------------------------
// audio_dma_interface_registers_top - audio DMA register block
// Two-slot buffer queue, control/status, DAC rate and bit rate registers.
// ----------------------------------------------------------------------------
// Sequence: a read, write or played event goes from the accepted request to
//   ST_RESP and then into the response register; a DAC rate write first runs
//   two chained 32-step divisions (frequency, then period) in the one shared divider.
// Flow: one request at a time; a new request is taken once the previous one
//   has moved into the response register, which waits on rsp_tready.
// Reset (synchronous, active high): queue empty, slots zero, rates zero,
//   frequency = clock rate, period = period clock / clock rate.
module audio_dma_interface_registers_top (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // [1:0] func
   input  logic [55:0]  req_tdata,   // [19:0] bus_offset, [51:20] write_data, rest zero
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] read_data, [32] irq_clear, [64:33] sample_frequency,
   // [96:65] sample_period, [101:97] sample_bits, [125:102] play_address,
   // [143:126] play_length
   output logic [143:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_FREQ,
      ST_DIV_PERIOD,
      ST_RESP
   } state_type;

   localparam int IW = adir_pkg::IDX_W;

   // request unpacking
   logic [1:0]    req_func;
   logic [IW-1:0] req_idx;
   logic [31:0]   req_data;
   logic          req_fire;

   assign req_func = req_tuser;
   assign req_idx  = req_tdata[19:2];
   assign req_data = req_tdata[51:20];

   // control and architectural state
   state_type     state_ff, state_in;
   logic [1:0]    func_ff, func_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic [23:0]   slot_addr_ff [2];
   logic [23:0]   slot_addr_in [2];
   logic [17:0]   slot_len_ff  [2];
   logic [17:0]   slot_len_in  [2];
   logic          wr_slot_ff, wr_slot_in;
   logic          play_slot_ff, play_slot_in;
   logic [1:0]    pend_ff, pend_in;
   logic          dma_en_ff, dma_en_in;
   logic [13:0]   dac_rate_ff, dac_rate_in;
   logic [3:0]    bit_rate_ff, bit_rate_in;
   logic [31:0]   freq_ff, freq_in;
   logic [31:0]   period_ff, period_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [143:0]  rsp_data_ff, rsp_data_in;

   // shared divider
   adir_pkg::div_req_type  div_req;
   adir_pkg::div_stat_type div_stat;
   logic [31:0]            div_q;
   logic [31:0]            freq_clamped;
   logic [14:0]            rate_plus_one;

   adir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat),
      .quotient (div_q)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // frequency never drops below one
   assign freq_clamped  = (div_q == 32'd0) ? 32'd1 : div_q;
   assign rate_plus_one = {1'b0, req_data[13:0]} + 15'd1;

   // response word, built from state that is already final
   logic [31:0] rd_value;
   logic        irq_clr;
   logic [23:0] play_addr;
   logic [17:0] play_len;
   logic        rsp_load;

   always_comb begin
      rd_value = 32'd0;
      if (func_ff == adir_pkg::FUNC_READ) begin
         case (idx_ff)
            adir_pkg::REG_LENGTH: begin
               if (pend_ff != 2'd0) rd_value = {14'd0, slot_len_ff[play_slot_ff]};
            end
            adir_pkg::REG_CONTROL:  rd_value = {31'd0, dma_en_ff};
            adir_pkg::REG_STATUS: begin
               rd_value[0]  = (pend_ff == 2'd2);
               rd_value[31] = (pend_ff == 2'd2);
               rd_value[30] = (pend_ff != 2'd0) && dma_en_ff;
            end
            adir_pkg::REG_DAC_RATE: rd_value = {18'd0, dac_rate_ff};
            adir_pkg::REG_BIT_RATE: rd_value = {28'd0, bit_rate_ff};
            default:                rd_value = 32'd0;
         endcase
      end
      irq_clr   = (func_ff == adir_pkg::FUNC_WRITE) && (idx_ff == adir_pkg::REG_STATUS);
      play_addr = (pend_ff != 2'd0) ? slot_addr_ff[play_slot_ff] : 24'd0;
      play_len  = (pend_ff != 2'd0) ? slot_len_ff[play_slot_ff]  : 18'd0;
      rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      slot_addr_in = slot_addr_ff;
      slot_len_in  = slot_len_ff;
      wr_slot_in   = wr_slot_ff;
      play_slot_in = play_slot_ff;
      pend_in      = pend_ff;
      dma_en_in    = dma_en_ff;
      dac_rate_in  = dac_rate_ff;
      bit_rate_in  = bit_rate_ff;
      freq_in      = freq_ff;
      period_in    = period_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      div_req.start    = 1'b0;
      div_req.dividend = adir_pkg::CLOCK_RATE;
      div_req.divisor  = {17'd0, rate_plus_one};

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_func;
               idx_in   = req_idx;
               state_in = ST_RESP;
               if (req_func == adir_pkg::FUNC_WRITE) begin
                  case (req_idx)
                     adir_pkg::REG_ADDRESS: begin
                        if (pend_ff != 2'd2)
                           slot_addr_in[wr_slot_ff] = {req_data[23:3], 3'b000};
                     end
                     adir_pkg::REG_LENGTH: begin
                        if (pend_ff != 2'd2) begin
                           slot_len_in[wr_slot_ff] = {req_data[17:3], 3'b000};
                           wr_slot_in = ~wr_slot_ff;
                           pend_in    = pend_ff + 2'd1;
                        end
                     end
                     adir_pkg::REG_CONTROL: dma_en_in = req_data[0];
                     adir_pkg::REG_DAC_RATE: begin
                        dac_rate_in   = req_data[13:0];
                        div_req.start = 1'b1;
                        state_in      = ST_DIV_FREQ;
                     end
                     adir_pkg::REG_BIT_RATE: bit_rate_in = req_data[3:0];
                     default: ;
                  endcase
               end else if (req_func == adir_pkg::FUNC_PLAYED) begin
                  if (pend_ff != 2'd0) begin
                     play_slot_in = ~play_slot_ff;
                     pend_in      = pend_ff - 2'd1;
                  end
               end
            end
         end
         ST_DIV_FREQ: begin
            // chain the period division right behind the frequency result
            if (div_stat.done) begin
               freq_in          = freq_clamped;
               div_req.start    = 1'b1;
               div_req.dividend = adir_pkg::PERIOD_CLOCK;
               div_req.divisor  = freq_clamped;
               state_in         = ST_DIV_PERIOD;
            end
         end
         ST_DIV_PERIOD: begin
            if (div_stat.done) begin
               period_in = div_q;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {play_len, play_addr, {1'b0, bit_rate_ff} + 5'd1,
                               period_ff, freq_ff, irq_clr, rd_value};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         slot_addr_ff[0] <= 24'd0;
         slot_addr_ff[1] <= 24'd0;
         slot_len_ff[0]  <= 18'd0;
         slot_len_ff[1]  <= 18'd0;
         wr_slot_ff      <= 1'b0;
         play_slot_ff    <= 1'b0;
         pend_ff         <= 2'd0;
         dma_en_ff       <= 1'b0;
         dac_rate_ff     <= 14'd0;
         bit_rate_ff     <= 4'd0;
         freq_ff         <= adir_pkg::CLOCK_RATE;
         period_ff       <= adir_pkg::PERIOD_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_addr_ff <= slot_addr_in;
         slot_len_ff  <= slot_len_in;
         wr_slot_ff   <= wr_slot_in;
         play_slot_ff <= play_slot_in;
         pend_ff      <= pend_in;
         dma_en_ff    <= dma_en_in;
         dac_rate_ff  <= dac_rate_in;
         bit_rate_ff  <= bit_rate_in;
         freq_ff      <= freq_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // queue pointers agree with the pending count
   a_queue_ptrs: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 2'd1) == (wr_slot_ff != play_slot_ff))
      else $error("queue pointers disagree with pending count");

   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("pending count overflow");

   // divider only runs while a rate update is in flight
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESP) |-> !div_stat.busy)
      else $error("divider busy outside a rate update");

   a_rate_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == adir_pkg::FUNC_WRITE &&
       req_idx == adir_pkg::REG_DAC_RATE) |=> div_stat.busy)
      else $error("rate write did not start the divider");

   a_freq_nonzero: assert property (@(posedge clock) disable iff (reset)
      freq_ff != 32'd0)
      else $error("sample frequency reached zero");

endmodule
